[rtl/core/bavs_pkg.sv]
// Shared types, constants and the exp2 coefficient table for the barometric
// altitude and vertical speed unit. No dependencies.
`timescale 1ns / 1ps

package bavs_pkg;

    // Datapath operation codes issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_LOGA_INIT = 4'd2;
    localparam logic [3:0] OP_LOGB_INIT = 4'd3;
    localparam logic [3:0] OP_LOG_STEP  = 4'd4;
    localparam logic [3:0] OP_EXPO      = 4'd5;
    localparam logic [3:0] OP_EXP_STEP  = 4'd6;
    localparam logic [3:0] OP_TERM      = 4'd7;
    localparam logic [3:0] OP_ALT       = 4'd8;
    localparam logic [3:0] OP_NUM       = 4'd9;
    localparam logic [3:0] OP_DIVV_LOAD = 4'd10;
    localparam logic [3:0] OP_DIV_STEP  = 4'd11;
    localparam logic [3:0] OP_ACC       = 4'd12;
    localparam logic [3:0] OP_SMOOTH    = 4'd13;
    localparam logic [3:0] OP_DONE      = 4'd14;
    localparam logic [3:0] OP_TEN_HI    = 4'd15;

    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;
    localparam int DIV_BITS  = 54;

    localparam logic [15:0] ALT_SCALE    = 16'd44330;
    localparam logic [13:0] EXPONENT_Q16 = 14'd12471;
    localparam logic [19:0] US_PER_S     = 20'd1000000;

    // Multiply by this and shift right by 35 to divide a 32-bit value by ten.
    localparam logic [31:0] TEN_RECIP    = 32'hCCCC_CCCD;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic zero_dt;
        logic out_free;
    } t_stat;

    typedef logic [31:0] t_rom [EXP_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = x;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // Entry k holds 2^(2^-(k+1)) in Q2.30, built by a chain of square roots.
    function automatic t_rom build_rom();
        t_rom        r;
        logic [63:0] v;
        v    = isqrt64(64'd1 << 61);
        r[0] = v[31:0];
        for (int k = 1; k < EXP_STEPS; k++) begin
            v    = isqrt64(v << 30);
            r[k] = v[31:0];
        end
        return r;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

endpackage

[rtl/core/baro_altitude_vspeed_unit.sv]
// Barometric altitude with smoothed vertical speed. Each pressure word runs
// through the 16-step log2 and exp2 sequences on one 32x32 multiplier and,
// when the timestamp advanced, the 54-step restoring divide by the time
// difference; the next word is accepted only once the last one is finished
// and its result has moved into the output register.
// One word is processed at a time; a finished result waits in an output
// register while the next word is accepted. The first word sets the
// reference pressure and reports altitude zero.
`timescale 1ns / 1ps

module baro_altitude_vspeed_unit import bavs_pkg::*; #(
    parameter int PRESSURE_BITS = 24,
    parameter int TIME_BITS     = 32,
    parameter int FRAC_BITS     = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PRESSURE_BITS-1:0] i_pressure_sample,
    input  logic [TIME_BITS-1:0]     i_timestamp_us,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_altitude,
    output logic signed [31:0]       o_vertical_speed,
    output logic                     o_zero_interval
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bavs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bavs_datapath #(
        .PRESSURE_BITS (PRESSURE_BITS),
        .TIME_BITS     (TIME_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_pressure_sample (i_pressure_sample),
        .i_timestamp_us    (i_timestamp_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_altitude        (o_altitude),
        .o_vertical_speed  (o_vertical_speed),
        .o_zero_interval   (o_zero_interval)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice without finishing a word");

    a_idle_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_cmd.op == OP_LOAD || w_cmd.op == OP_NONE))
        else $error("datapath command issued while idle");

    a_divide_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_DIV_STEP) |-> !o_in_ready)
        else $error("divider stepping while input is ready");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");
`endif

endmodule

[rtl/core/bavs_ctrl.sv]
// Sequencing state machine for the altitude and speed unit.
// Depends on bavs_pkg for the command and status types.
`timescale 1ns / 1ps

module bavs_ctrl import bavs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOGA_INIT = 4'd1;
    localparam logic [3:0] S_LOGA      = 4'd2;
    localparam logic [3:0] S_LOGB_INIT = 4'd3;
    localparam logic [3:0] S_LOGB      = 4'd4;
    localparam logic [3:0] S_EXPO      = 4'd5;
    localparam logic [3:0] S_EXP       = 4'd6;
    localparam logic [3:0] S_TERM      = 4'd7;
    localparam logic [3:0] S_ALT       = 4'd8;
    localparam logic [3:0] S_NUM       = 4'd9;
    localparam logic [3:0] S_DIVV_LOAD = 4'd10;
    localparam logic [3:0] S_DIVV      = 4'd11;
    localparam logic [3:0] S_ACC       = 4'd12;
    localparam logic [3:0] S_TEN_HI    = 4'd13;
    localparam logic [3:0] S_SMOOTH    = 4'd14;
    localparam logic [3:0] S_DONE      = 4'd15;

    localparam logic [5:0] LOG_LAST = 6'(LOG_STEPS - 1);
    localparam logic [5:0] EXP_LAST = 6'(EXP_STEPS - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_cnt[3:0];
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_LOGA_INIT;
                end
            end
            S_LOGA_INIT: begin
                o_cmd.op = OP_LOGA_INIT;
                n_cnt    = '0;
                n_state  = S_LOGA;
            end
            S_LOGA: begin
                o_cmd.op = OP_LOG_STEP;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == LOG_LAST) begin
                    n_state = S_LOGB_INIT;
                end
            end
            S_LOGB_INIT: begin
                o_cmd.op = OP_LOGB_INIT;
                n_cnt    = '0;
                n_state  = S_LOGB;
            end
            S_LOGB: begin
                o_cmd.op = OP_LOG_STEP;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == LOG_LAST) begin
                    n_state = S_EXPO;
                end
            end
            S_EXPO: begin
                o_cmd.op = OP_EXPO;
                n_cnt    = '0;
                n_state  = S_EXP;
            end
            S_EXP: begin
                o_cmd.op = OP_EXP_STEP;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == EXP_LAST) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                o_cmd.op = OP_TERM;
                n_state  = S_ALT;
            end
            S_ALT: begin
                o_cmd.op = OP_ALT;
                // With no elapsed time the speed is held, so skip the update.
                n_state  = i_stat.zero_dt ? S_DONE : S_NUM;
            end
            S_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_DIVV_LOAD;
            end
            S_DIVV_LOAD: begin
                o_cmd.op = OP_DIVV_LOAD;
                n_cnt    = '0;
                n_state  = S_DIVV;
            end
            S_DIVV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_TEN_HI;
            end
            S_TEN_HI: begin
                o_cmd.op = OP_TEN_HI;
                n_state  = S_SMOOTH;
            end
            S_SMOOTH: begin
                o_cmd.op = OP_SMOOTH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/bavs_datapath.sv]
// Datapath of the altitude and speed unit: log2, exp2, scaling, a restoring
// divider, a two-step divide by ten, the smoothing filter and the output register.
// Depends on bavs_pkg for op codes, constants and the exp2 table.
`timescale 1ns / 1ps

module bavs_datapath import bavs_pkg::*; #(
    parameter int PRESSURE_BITS = 24,
    parameter int TIME_BITS     = 32,
    parameter int FRAC_BITS     = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic [PRESSURE_BITS-1:0]   i_pressure_sample,
    input  logic [TIME_BITS-1:0]       i_timestamp_us,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_altitude,
    output logic signed [31:0]         o_vertical_speed,
    output logic                       o_zero_interval
);

    localparam logic signed [49:0] ALT_ZERO = 50'(ALT_SCALE) << FRAC_BITS;
    localparam logic signed [6:0]  SHIFT_BASE = 7'(30 - FRAC_BITS);

    function automatic logic [4:0] lead_one(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // Architectural state.
    logic [31:0]                 r_ref_p;
    logic                        r_ref_valid;
    logic signed [31:0]          r_prev_alt;
    logic [TIME_BITS-1:0]        r_prev_time;
    logic signed [31:0]          r_speed;

    // Working registers for one word.
    logic [31:0]                 r_p;
    logic [TIME_BITS-1:0]        r_t;
    logic [TIME_BITS-1:0]        r_dt;
    logic                        r_zero;
    logic [31:0]                 r_m;
    logic [4:0]                  r_lead;
    logic [15:0]                 r_frac;
    logic [20:0]                 r_log_a;
    logic signed [3:0]           r_n;
    logic [15:0]                 r_f;
    logic [31:0]                 r_y;
    logic [47:0]                 r_prod;
    logic signed [31:0]          r_alt;
    logic signed [53:0]          r_num;
    logic [53:0]                 r_dq;
    logic [31:0]                 r_dr;
    logic [31:0]                 r_dd;
    logic                        r_dneg;

    logic                        r_out_valid;
    logic signed [31:0]          r_out_alt;
    logic signed [31:0]          r_out_spd;
    logic                        r_out_zero;

    logic [31:0]                 w_p_in;
    logic [31:0]                 w_mul_a;
    logic [31:0]                 w_mul_b;
    logic [63:0]                 w_mul;
    logic [32:0]                 w_m2;
    logic [63:0]                 w_y_next;
    logic signed [21:0]          w_d;
    logic signed [37:0]          w_e;
    logic signed [6:0]           w_s;
    logic [5:0]                  w_sh;
    logic [49:0]                 w_term;
    logic signed [49:0]          w_alt_wide;
    logic signed [31:0]          w_alt_sat;
    logic signed [32:0]          w_diff;
    logic [53:0]                 w_num_mag;
    logic [32:0]                 w_rem_sh;
    logic                        w_rem_ge;
    logic signed [31:0]          w_raw;
    logic signed [35:0]          w_acc;
    logic [35:0]                 w_acc_mag;
    logic [19:0]                 w_ten_in;
    logic [63:0]                 w_ten_prod;
    logic [19:0]                 w_ten_q;
    logic [19:0]                 w_ten_r;
    logic [31:0]                 w_quot;
    logic                        w_out_free;

    assign w_p_in = (i_pressure_sample == '0) ? 32'd1 : 32'(i_pressure_sample);

    // One multiplier serves both the log2 squaring and the exp2 products.
    assign w_mul_a  = (i_cmd.op == OP_EXP_STEP) ? r_y : r_m;
    assign w_mul_b  = (i_cmd.op == OP_EXP_STEP) ? EXP_ROM[i_cmd.step] : r_m;
    assign w_mul    = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_m2     = w_mul[63:31];
    assign w_y_next = (w_mul + 64'h2000_0000) >> 30;

    assign w_d = $signed({1'b0, r_log_a}) - $signed({1'b0, r_lead, r_frac});
    assign w_e = (38'(w_d) * 38'sd12471 + 38'sd32768) >>> 16;

    assign w_s      = SHIFT_BASE - 7'(r_n);
    assign w_sh     = w_s[5:0];
    assign w_term   = (50'(r_prod) + (50'd1 << (w_sh - 6'd1))) >> w_sh;
    assign w_alt_wide = ALT_ZERO - $signed(w_term);
    assign w_alt_sat  = (w_alt_wide > 50'sd2147483647)  ? 32'sh7FFF_FFFF :
                        (w_alt_wide < -50'sd2147483648) ? 32'sh8000_0000 :
                        w_alt_wide[31:0];

    assign w_diff    = 33'(r_alt) - 33'(r_prev_alt);
    assign w_num_mag = r_num[53] ? 54'(-r_num) : 54'(r_num);

    assign w_rem_sh = {r_dr, r_dq[53]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_dd});

    // Signed, saturated raw speed from the divider quotient.
    always_comb begin
        if (r_dneg) begin
            w_raw = (r_dq > 54'd2147483648) ? 32'sh8000_0000 : -$signed(r_dq[31:0]);
        end else begin
            w_raw = (r_dq > 54'd2147483647) ? 32'sh7FFF_FFFF : $signed(r_dq[31:0]);
        end
    end

    assign w_acc     = 36'(r_speed) * 36'sd9 + 36'(w_raw);
    assign w_acc_mag = w_acc[35] ? 36'(-w_acc) : 36'(w_acc);

    // The divide by ten runs as two digits of a long division: first the upper
    // 20 bits, then the remainder joined with the lower 16 bits.
    assign w_ten_in   = (i_cmd.op == OP_TEN_HI) ? r_dq[35:16] : r_dq[19:0];
    assign w_ten_prod = 64'(w_ten_in) * 64'(TEN_RECIP);
    assign w_ten_q    = w_ten_prod[54:35];
    assign w_ten_r    = w_ten_in - w_ten_q * 20'd10;
    assign w_quot     = {r_dr[15:0], 16'h0000} + 32'(w_ten_q);

    assign w_out_free      = !r_out_valid || i_out_ready;
    assign o_stat.zero_dt  = r_zero;
    assign o_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_p     <= '0;
            r_ref_valid <= 1'b0;
            r_prev_alt  <= '0;
            r_prev_time <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_NONE: begin
                end
                OP_LOAD: begin
                    r_p    <= w_p_in;
                    r_t    <= i_timestamp_us;
                    r_dt   <= i_timestamp_us - r_prev_time;
                    r_zero <= (i_timestamp_us == r_prev_time);
                    if (!r_ref_valid) begin
                        r_ref_p     <= w_p_in;
                        r_ref_valid <= 1'b1;
                    end
                end
                OP_LOGA_INIT: begin
                    r_lead <= lead_one(r_p);
                    r_m    <= r_p << (5'd31 - lead_one(r_p));
                    r_frac <= '0;
                end
                OP_LOGB_INIT: begin
                    r_log_a <= {r_lead, r_frac};
                    r_lead  <= lead_one(r_ref_p);
                    r_m     <= r_ref_p << (5'd31 - lead_one(r_ref_p));
                    r_frac  <= '0;
                end
                OP_LOG_STEP: begin
                    // Squaring the mantissa doubles the log; an overflow past
                    // two yields the next fraction bit.
                    r_frac <= {r_frac[14:0], w_m2[32]};
                    r_m    <= w_m2[32] ? w_m2[32:1] : w_m2[31:0];
                end
                OP_EXPO: begin
                    r_n <= w_e[19:16];
                    r_f <= w_e[15:0];
                    r_y <= 32'h4000_0000;
                end
                OP_EXP_STEP: begin
                    if (r_f[4'd15 - i_cmd.step]) begin
                        r_y <= w_y_next[31:0];
                    end
                end
                OP_TERM: begin
                    r_prod <= 48'(r_y) * 48'(ALT_SCALE);
                end
                OP_ALT: begin
                    r_alt <= w_alt_sat;
                end
                OP_NUM: begin
                    r_num <= 54'(w_diff) * $signed(54'(US_PER_S));
                end
                OP_DIVV_LOAD: begin
                    r_dq   <= w_num_mag + 54'(r_dt >> 1);
                    r_dr   <= '0;
                    r_dd   <= 32'(r_dt);
                    r_dneg <= r_num[53];
                end
                OP_DIV_STEP: begin
                    if (w_rem_ge) begin
                        r_dr <= 32'(w_rem_sh - {1'b0, r_dd});
                    end else begin
                        r_dr <= w_rem_sh[31:0];
                    end
                    r_dq <= {r_dq[52:0], w_rem_ge};
                end
                OP_ACC: begin
                    // Rounding half away from zero of the divide by ten.
                    r_dq   <= 54'(w_acc_mag) + 54'd5;
                    r_dneg <= w_acc[35];
                end
                OP_TEN_HI: begin
                    r_dr <= 32'(w_ten_q);
                    r_dq <= 54'({w_ten_r[3:0], r_dq[15:0]});
                end
                OP_SMOOTH: begin
                    r_speed <= r_dneg ? -$signed(w_quot) : $signed(w_quot);
                end
                OP_DONE: begin
                    r_prev_alt  <= r_alt;
                    r_prev_time <= r_t;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DONE) begin
            r_out_alt  <= r_alt;
            r_out_spd  <= r_speed;
            r_out_zero <= r_zero;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_altitude       = r_out_alt;
    assign o_vertical_speed = r_out_spd;
    assign o_zero_interval  = r_out_zero;

endmodule
